[rtl/stq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sleep timer queue
// Cell commands, status codes and the arithmetic constants of the wake time.
// ----------------------------------------------------------------------------
package stq_pkg;

	localparam int TIME_BITS              = 64;
	localparam int DEFAULT_QUEUE_DEPTH    = 32;
	localparam int DEFAULT_WAITER_ID_BITS = 8;
	localparam int MAX_RESULTS            = 32;

	// seconds to ticks
	localparam int MS_PER_SEC      = 1000;
	localparam int MS_BITS         = 10;
	localparam int SEC_PROD_BITS   = 32 + MS_BITS;

	// microseconds / 1000 as multiply by ceil(2^38 / 1000), then shift by 38
	localparam int DIV_MAGIC       = 274877907;
	localparam int DIV_MAGIC_BITS  = 29;
	localparam int DIV_SHIFT       = 38;
	localparam int USEC_PROD_BITS  = 32 + DIV_MAGIC_BITS;
	localparam int DELAY_BITS      = SEC_PROD_BITS + 1;

	localparam logic [1:0] ST_ACCEPTED = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_WOKEN    = 2'd2;
	localparam logic [1:0] ST_IDLE     = 2'd3;

	localparam logic KIND_SLEEP = 1'b0;
	localparam logic KIND_TICK  = 1'b1;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_POP
	} cell_op_t;

endpackage

[rtl/sleep_timer_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sleep_timer_queue: queue of sleeping waiters ordered by wake time
// Sorted chain of cells with a small sequencer in front of it.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer. kind 0
//   is a sleep request: waiter_id sleeps until elapsed + seconds*1000 +
//   microseconds/1000 + 1 ticks (saturating at 2^64-1). kind 1 adds
//   tick_count to the elapsed tick counter and releases every due waiter.
//   Output channel (out_valid / out_stall) returns status, woken_waiter and
//   last. A sleep gets one result: accepted, or full when all slots are used.
//   A tick gets one woken result per released waiter (earliest wake time
//   first, ties in insertion order, at most 32 per tick), or one idle result.
//   Sequence: a sleep request is scaled at its transfer, summed in S_SLP_SUM
//   and inserted into the chain with its result loaded in S_SLP_INS once the
//   output register is free; the next transfer can follow in S_IDLE. A tick
//   updates the counter at its transfer and loads its first result from
//   S_REL, then 1 result per cycle while the output register is free; the
//   release rate is set by the chain shifting one cell per popped waiter.
//   One item is in flight at a time: in_stall stays high from the transfer
//   until the item's last result is loaded into the output register.
//   Reset clears the elapsed counter and empties the chain at once.
//   A stalled receiver holds the output register; the sequencer waits.
// ----------------------------------------------------------------------------
module sleep_timer_queue #(
	parameter int QUEUE_DEPTH    = stq_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int WAITER_ID_BITS = stq_pkg::DEFAULT_WAITER_ID_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      kind,
	input  logic [WAITER_ID_BITS-1:0] waiter_id,
	input  logic [31:0]               sleep_seconds,
	input  logic [31:0]               sleep_microseconds,
	input  logic [31:0]               tick_count,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [1:0]                status,
	output logic [WAITER_ID_BITS-1:0] woken_waiter,
	output logic                      last
);

	localparam int TB      = stq_pkg::TIME_BITS;
	localparam int CNT_BITS = $clog2(stq_pkg::MAX_RESULTS);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SLP_SUM,
		S_SLP_INS,
		S_REL
	} state_t;

	state_t                              state_q;
	logic [TB-1:0]                       elapsed_q;
	logic [stq_pkg::SEC_PROD_BITS-1:0]   sec_prod_s1;
	logic [stq_pkg::USEC_PROD_BITS-1:0]  usec_prod_s1;
	logic [WAITER_ID_BITS-1:0]           id_q;
	logic [TB-1:0]                       wake_q;
	logic [CNT_BITS-1:0]                 rel_cnt_q;
	logic                                out_valid_q;
	logic [1:0]                          status_q;
	logic [WAITER_ID_BITS-1:0]           woken_q;
	logic                                last_q;

	logic                                accept;
	logic                                out_free;
	logic                                out_load;
	logic [TB:0]                         tick_sum;
	logic [stq_pkg::DELAY_BITS-1:0]      delay;
	logic [TB:0]                         wake_sum;
	stq_pkg::cell_op_t                   cmd;
	logic                                rel_last;

	// per-cell chain signals
	logic [QUEUE_DEPTH-1:0]              c_keep;
	logic [QUEUE_DEPTH-1:0]              c_valid;
	logic [QUEUE_DEPTH-1:0]              c_due;
	logic [TB-1:0]                       c_wake [QUEUE_DEPTH];
	logic [WAITER_ID_BITS-1:0]           c_id   [QUEUE_DEPTH];

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	// a result is loaded whenever a producing state finds the register free
	assign out_load  = out_free && ((state_q == S_SLP_INS) || (state_q == S_REL));

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign woken_waiter = woken_q;
	assign last         = last_q;

	// saturating counter update and wake time sum
	assign tick_sum = {1'b0, elapsed_q} + {{(TB + 1 - 32){1'b0}}, tick_count};
	assign delay    = {1'b0, sec_prod_s1}
	                + stq_pkg::DELAY_BITS'(usec_prod_s1 >> stq_pkg::DIV_SHIFT)
	                + stq_pkg::DELAY_BITS'(1);
	assign wake_sum = {1'b0, elapsed_q} + {{(TB + 1 - stq_pkg::DELAY_BITS){1'b0}}, delay};

	// last woken result: next in line not due, or release cap reached
	assign rel_last = !c_due[1] || (rel_cnt_q == CNT_BITS'(stq_pkg::MAX_RESULTS - 1));

	always_comb begin
		cmd = stq_pkg::CELL_HOLD;
		if (out_free) begin
			if (state_q == S_SLP_INS && !c_valid[QUEUE_DEPTH-1]) begin
				cmd = stq_pkg::CELL_INSERT;
			end else if (state_q == S_REL && c_due[0]) begin
				cmd = stq_pkg::CELL_POP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			elapsed_q    <= '0;
			sec_prod_s1  <= '0;
			usec_prod_s1 <= '0;
			id_q         <= '0;
			wake_q       <= '0;
			rel_cnt_q    <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= stq_pkg::ST_ACCEPTED;
			woken_q      <= '0;
			last_q       <= 1'b0;
		end else begin
			// load a new result, or drop the held one once taken
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind == stq_pkg::KIND_SLEEP) begin
							sec_prod_s1  <= stq_pkg::SEC_PROD_BITS'(sleep_seconds)
							              * stq_pkg::SEC_PROD_BITS'(stq_pkg::MS_PER_SEC);
							usec_prod_s1 <= stq_pkg::USEC_PROD_BITS'(sleep_microseconds)
							              * stq_pkg::USEC_PROD_BITS'(stq_pkg::DIV_MAGIC);
							id_q         <= waiter_id;
							state_q      <= S_SLP_SUM;
						end else begin
							elapsed_q <= tick_sum[TB] ? {TB{1'b1}} : tick_sum[TB-1:0];
							rel_cnt_q <= '0;
							state_q   <= S_REL;
						end
					end
				end
				S_SLP_SUM: begin
					wake_q  <= wake_sum[TB] ? {TB{1'b1}} : wake_sum[TB-1:0];
					state_q <= S_SLP_INS;
				end
				S_SLP_INS: begin
					if (out_free) begin
						status_q    <= c_valid[QUEUE_DEPTH-1] ? stq_pkg::ST_FULL
						                                      : stq_pkg::ST_ACCEPTED;
						woken_q     <= '0;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				S_REL: begin
					if (out_free) begin
						if (!c_due[0]) begin
							// nobody due on this tick
							status_q <= stq_pkg::ST_IDLE;
							woken_q  <= '0;
							last_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							status_q  <= stq_pkg::ST_WOKEN;
							woken_q   <= c_id[0];
							last_q    <= rel_last;
							rel_cnt_q <= rel_cnt_q + CNT_BITS'(1);
							if (rel_last) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// sorted chain: cell 0 holds the earliest wake time
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                      p_keep;
		logic                      p_valid;
		logic [TB-1:0]             p_wake;
		logic [WAITER_ID_BITS-1:0] p_id;
		logic                      n_valid;
		logic [TB-1:0]             n_wake;
		logic [WAITER_ID_BITS-1:0] n_id;

		if (i == 0) begin : g_head
			assign p_keep  = 1'b1;
			assign p_valid = 1'b0;
			assign p_wake  = '0;
			assign p_id    = '0;
		end else begin : g_body
			assign p_keep  = c_keep[i-1];
			assign p_valid = c_valid[i-1];
			assign p_wake  = c_wake[i-1];
			assign p_id    = c_id[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_wake  = '0;
			assign n_id    = '0;
		end else begin : g_inner
			assign n_valid = c_valid[i+1];
			assign n_wake  = c_wake[i+1];
			assign n_id    = c_id[i+1];
		end

		stq_cell #(
			.ID_BITS (WAITER_ID_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.ins_wake   (wake_q),
			.ins_id     (id_q),
			.elapsed    (elapsed_q),
			.prev_keep  (p_keep),
			.prev_valid (p_valid),
			.prev_wake  (p_wake),
			.prev_id    (p_id),
			.next_valid (n_valid),
			.next_wake  (n_wake),
			.next_id    (n_id),
			.keep       (c_keep[i]),
			.valid      (c_valid[i]),
			.wake       (c_wake[i]),
			.id         (c_id[i]),
			.due        (c_due[i])
		);
	end

endmodule

[rtl/stq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_cell: one slot of the sorted waiter chain
// Holds one waiter; on insert it keeps, loads the new waiter or takes its
// left neighbor; on pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module stq_cell #(
	parameter int ID_BITS = stq_pkg::DEFAULT_WAITER_ID_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  stq_pkg::cell_op_t             cmd,
	input  logic [stq_pkg::TIME_BITS-1:0] ins_wake,
	input  logic [ID_BITS-1:0]            ins_id,
	input  logic [stq_pkg::TIME_BITS-1:0] elapsed,
	input  logic                          prev_keep,
	input  logic                          prev_valid,
	input  logic [stq_pkg::TIME_BITS-1:0] prev_wake,
	input  logic [ID_BITS-1:0]            prev_id,
	input  logic                          next_valid,
	input  logic [stq_pkg::TIME_BITS-1:0] next_wake,
	input  logic [ID_BITS-1:0]            next_id,
	output logic                          keep,
	output logic                          valid,
	output logic [stq_pkg::TIME_BITS-1:0] wake,
	output logic [ID_BITS-1:0]            id,
	output logic                          due
);

	logic                          valid_q;
	logic [stq_pkg::TIME_BITS-1:0] wake_q;
	logic [ID_BITS-1:0]            id_q;

	// stay put on insert when an equal or earlier wake time lives here
	assign keep  = valid_q && (wake_q <= ins_wake);
	assign due   = valid_q && (wake_q < elapsed);
	assign valid = valid_q;
	assign wake  = wake_q;
	assign id    = id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd)
				stq_pkg::CELL_INSERT: begin
					if (!keep) begin
						valid_q <= prev_keep ? 1'b1 : prev_valid;
					end
				end
				stq_pkg::CELL_POP: valid_q <= next_valid;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			stq_pkg::CELL_INSERT: begin
				if (!keep) begin
					wake_q <= prev_keep ? ins_wake : prev_wake;
					id_q   <= prev_keep ? ins_id : prev_id;
				end
			end
			stq_pkg::CELL_POP: begin
				wake_q <= next_wake;
				id_q   <= next_id;
			end
			default: begin
				wake_q <= wake_q;
				id_q   <= id_q;
			end
		endcase
	end

endmodule

[rtl/stq_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_checker: port-level checks of the sleep timer queue
// Watches the top level ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
module stq_checker #(
	parameter int ID_BITS = stq_pkg::DEFAULT_WAITER_ID_BITS
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic [ID_BITS-1:0] woken_waiter,
	input logic               last
);

	// one item at a time: a transfer closes the input for the next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input transfer taken while an item is in flight");

	// only woken results can continue a burst
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != stq_pkg::ST_WOKEN |-> last)
		else $error("non-woken result without last");

	// woken_waiter carries an id only for woken results
	a_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != stq_pkg::ST_WOKEN |-> woken_waiter == '0)
		else $error("woken_waiter set on a non-woken result");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(woken_waiter) && $stable(last))
		else $error("stalled result changed");

endmodule

bind sleep_timer_queue stq_checker #(
	.ID_BITS (WAITER_ID_BITS)
) u_stq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.woken_waiter (woken_waiter),
	.last         (last)
);

[verif/sleep_timer_queue_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sleep_timer_queue_checker: result predictor and scoreboard
// Watches both channels of the sleep timer queue, tracks the sleeping waiters
// and the elapsed tick count itself, and compares every result transfer with
// the oldest predicted reply.
// ----------------------------------------------------------------------------
module sleep_timer_queue_checker #(
	parameter int QUEUE_DEPTH    = stq_pkg::DEFAULT_QUEUE_DEPTH,
	parameter int WAITER_ID_BITS = stq_pkg::DEFAULT_WAITER_ID_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      kind,
	input  logic [WAITER_ID_BITS-1:0] waiter_id,
	input  logic [31:0]               sleep_seconds,
	input  logic [31:0]               sleep_microseconds,
	input  logic [31:0]               tick_count,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [1:0]                status,
	input  logic [WAITER_ID_BITS-1:0] woken_waiter,
	input  logic                      last,
	output int                        mismatches,
	output int                        replies_outstanding
);

	localparam int TIME_BITS = stq_pkg::TIME_BITS;

	typedef struct packed {
		logic [1:0]                status;
		logic [WAITER_ID_BITS-1:0] woken;
		logic                      last;
	} reply_t;

	reply_t                    predicted_replies[$];
	int                        error_count = 0;

	logic [TIME_BITS-1:0]      now_ticks;
	logic [15:0]               insert_count;
	logic                      slot_busy[QUEUE_DEPTH];
	logic [TIME_BITS-1:0]      slot_wake[QUEUE_DEPTH];
	logic [WAITER_ID_BITS-1:0] slot_owner[QUEUE_DEPTH];
	logic [15:0]               slot_order[QUEUE_DEPTH];

	initial begin
		mismatches = 0;
		replies_outstanding = 0;
	end

	function automatic logic [TIME_BITS-1:0] saturating_add(logic [TIME_BITS-1:0] a,
			logic [TIME_BITS-1:0] b);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
	endfunction

	// earliest due waiter; among equal wake times the oldest insert wins
	function automatic int earliest_due_slot();
		int         best;
		logic [15:0] age;
		logic [15:0] best_age;
		best = -1;
		best_age = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (slot_busy[i] && slot_wake[i] < now_ticks) begin
				age = insert_count - slot_order[i];
				if (best < 0 || slot_wake[i] < slot_wake[best] ||
						(slot_wake[i] == slot_wake[best] && age > best_age)) begin
					best = i;
					best_age = age;
				end
			end
		end
		return best;
	endfunction

	function automatic void apply_sleep(logic [WAITER_ID_BITS-1:0] id, logic [31:0] secs,
			logic [31:0] usecs);
		int                   free_slot;
		logic [TIME_BITS-1:0] delay;
		free_slot = -1;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (!slot_busy[i]) begin
				free_slot = i;
				break;
			end
		end
		if (free_slot < 0) begin
			predicted_replies.push_back('{stq_pkg::ST_FULL, '0, 1'b1});
		end else begin
			delay = TIME_BITS'(secs) * TIME_BITS'(stq_pkg::MS_PER_SEC)
			      + TIME_BITS'(usecs / 32'(stq_pkg::MS_PER_SEC)) + TIME_BITS'(1);
			slot_busy[free_slot]  = 1'b1;
			slot_wake[free_slot]  = saturating_add(now_ticks, delay);
			slot_owner[free_slot] = id;
			slot_order[free_slot] = insert_count;
			insert_count++;
			predicted_replies.push_back('{stq_pkg::ST_ACCEPTED, '0, 1'b1});
		end
	endfunction

	function automatic void apply_tick(logic [31:0] ticks);
		int slot;
		int next_slot;
		int released;
		now_ticks = saturating_add(now_ticks, TIME_BITS'(ticks));
		released = 0;
		slot = earliest_due_slot();
		if (slot < 0)
			predicted_replies.push_back('{stq_pkg::ST_IDLE, '0, 1'b1});
		while (slot >= 0) begin
			slot_busy[slot] = 1'b0;
			released++;
			next_slot = (released < stq_pkg::MAX_RESULTS) ? earliest_due_slot() : -1;
			predicted_replies.push_back('{stq_pkg::ST_WOKEN, slot_owner[slot], next_slot < 0});
			slot = next_slot;
		end
	endfunction

	task automatic report_mismatch(string field, int unsigned want, int unsigned got);
		error_count++;
		$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			predicted_replies.delete();
			now_ticks = '0;
			insert_count = '0;
			for (int i = 0; i < QUEUE_DEPTH; i++)
				slot_busy[i] = 1'b0;
			replies_outstanding <= 0;
		end else begin
			// compare first: a result never comes from the item taken at the same edge
			if (out_valid && !out_stall) begin
				if (predicted_replies.size() == 0) begin
					report_mismatch("unexpected result, status", 0, 32'(status));
				end else begin
					want = predicted_replies.pop_front();
					if (status !== want.status)
						report_mismatch("status", 32'(want.status), 32'(status));
					if (woken_waiter !== want.woken)
						report_mismatch("woken_waiter", 32'(want.woken), 32'(woken_waiter));
					if (last !== want.last)
						report_mismatch("last", 32'(want.last), 32'(last));
				end
			end
			if (in_valid && !in_stall) begin
				if (kind == stq_pkg::KIND_SLEEP)
					apply_sleep(waiter_id, sleep_seconds, sleep_microseconds);
				else
					apply_tick(tick_count);
			end
			replies_outstanding <= predicted_replies.size();
			mismatches <= error_count;
		end
	end

endmodule

[verif/sleep_timer_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sleep_timer_queue_test: regression of the sleep timer queue
// Drives sleep requests and tick items in bursts against a stalling receiver,
// first a directed set around wake time boundaries and ties, then random
// episodes (floods to full, tie groups, ordinary traffic, idle ticks, noise).
// The checker beside the block predicts and scores every result.
// ----------------------------------------------------------------------------
module sleep_timer_queue_test;

	localparam int RANDOM_ITEMS   = 200;
	localparam int QUEUE_DEPTH_TB = stq_pkg::DEFAULT_QUEUE_DEPTH;

	typedef enum int {
		EP_PLAIN,
		EP_FLOOD,
		EP_TIES,
		EP_IDLE,
		EP_NOISE
	} episode_t;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_RUNS
	} stall_mode_t;

	logic        clk;
	logic        arst_n             = 1'b0;
	logic        in_valid           = 1'b0;
	logic        in_stall;
	logic        kind               = stq_pkg::KIND_SLEEP;
	logic [7:0]  waiter_id          = '0;
	logic [31:0] sleep_seconds      = '0;
	logic [31:0] sleep_microseconds = '0;
	logic [31:0] tick_count         = '0;
	logic        out_valid;
	logic        out_stall          = 1'b0;
	logic [1:0]  status;
	logic [7:0]  woken_waiter;
	logic        last;

	int mismatches;
	int replies_outstanding;

	// sender state: items left in the current burst and transfers so far
	int burst_left = 0;
	int transfers  = 0;

	// receiver state
	stall_mode_t stall_mode  = STALL_NONE;
	int          mode_cycles = 0;
	int          run_cycles  = 0;
	logic        run_stalled = 1'b0;

	sleep_timer_queue i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.kind               (kind),
		.waiter_id          (waiter_id),
		.sleep_seconds      (sleep_seconds),
		.sleep_microseconds (sleep_microseconds),
		.tick_count         (tick_count),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (status),
		.woken_waiter       (woken_waiter),
		.last               (last)
	);

	sleep_timer_queue_checker i_checker (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.kind                (kind),
		.waiter_id           (waiter_id),
		.sleep_seconds       (sleep_seconds),
		.sleep_microseconds  (sleep_microseconds),
		.tick_count          (tick_count),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.status              (status),
		.woken_waiter        (woken_waiter),
		.last                (last),
		.mismatches          (mismatches),
		.replies_outstanding (replies_outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: switch between no stall, scattered stalls and stall runs, each
	// mode held for a random stretch so stalls hit every phase of a release.
	always @(posedge clk) begin
		if (mode_cycles == 0) begin
			stall_mode  = stall_mode_t'($urandom_range(0, 2));
			mode_cycles = $urandom_range(30, 300);
		end else begin
			mode_cycles--;
		end
		case (stall_mode)
			STALL_NONE: begin
				out_stall <= 1'b0;
			end
			STALL_RANDOM: begin
				out_stall <= ($urandom_range(0, 2) == 0);
			end
			default: begin
				if (run_cycles == 0) begin
					run_stalled = !run_stalled;
					run_cycles  = run_stalled ? $urandom_range(1, 12) : $urandom_range(1, 5);
				end else begin
					run_cycles--;
				end
				out_stall <= run_stalled;
			end
		endcase
	end

	// Present one item and hold it until its transfer. Between most bursts,
	// drop valid for a random gap; inside a burst keep valid high and only swap
	// the payload, so valid is never lowered and raised in the same step.
	task automatic drive_item(logic item_kind, logic [7:0] id, logic [31:0] secs,
			logic [31:0] usecs, logic [31:0] ticks);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
			                                          : $urandom_range(1, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid           <= 1'b1;
		kind               <= item_kind;
		waiter_id          <= id;
		sleep_seconds      <= secs;
		sleep_microseconds <= usecs;
		tick_count         <= ticks;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		transfers++;
	endtask

	// fill the field a sleep request ignores with noise
	task automatic send_sleep(logic [7:0] id, logic [31:0] secs, logic [31:0] usecs);
		drive_item(stq_pkg::KIND_SLEEP, id, secs, usecs, $urandom);
	endtask

	// likewise for a tick item
	task automatic send_tick(logic [31:0] ticks);
		drive_item(stq_pkg::KIND_TICK, 8'($urandom), $urandom, $urandom, ticks);
	endtask

	// a sleep short enough to wake within a few thousand ticks
	task automatic send_short_sleep();
		send_sleep(8'($urandom), $urandom_range(0, 2), $urandom_range(0, 1999999));
	endtask

	initial begin
		int          random_start;
		int          count;
		int          pick;
		episode_t    episode;
		logic [31:0] tie_secs;
		int          tie_ms;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		send_tick(0);                              // idle tick straight after reset
		send_sleep(8'hFF, 32'd0, 32'd0);           // shortest sleep: wake at 1
		send_sleep(8'h00, 32'd0, 32'd999);         // quotient 0, ties with the one above
		send_sleep(8'hA5, 32'd0, 32'd1000);        // first whole millisecond: wake at 2
		send_sleep(8'h5A, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // longest sleep, never due here
		send_tick(1);                              // elapsed 1: wake 1 is not yet below
		send_tick(1);                              // elapsed 2: release the tie in order
		send_tick(0);                              // zero ticks, wake 2 still not below
		send_sleep(8'h01, 32'd1, 32'd0);           // three waiters, all wake at 1003
		send_sleep(8'h02, 32'd0, 32'd1000999);
		send_sleep(8'h03, 32'd0, 32'd1000000);
		send_tick(1000);                           // elapsed 1002: only 0xA5
		send_tick(1);                              // elapsed 1003: boundary, nobody
		send_tick(1);                              // elapsed 1004: tie group of three
		send_tick(32'hFFFF_FFFF);                  // largest tick count, still nobody
		send_sleep(8'h3C, 32'd1, 32'h8000_0000);
		send_tick(32'h0040_0000);                  // release it

		// --- random part, in episodes of well-formed traffic ---
		random_start = transfers;
		while (transfers - random_start < RANDOM_ITEMS) begin
			// open with a flood so the full queue is reached early
			if (transfers == random_start) begin
				episode = EP_FLOOD;
			end else begin
				pick = $urandom_range(0, 11);
				if (pick < 5)
					episode = EP_PLAIN;
				else if (pick < 6)
					episode = EP_FLOOD;
				else if (pick < 8)
					episode = EP_TIES;
				else if (pick < 10)
					episode = EP_IDLE;
				else
					episode = EP_NOISE;
			end
			case (episode)
				EP_PLAIN: begin
					count = $urandom_range(2, 8);
					repeat (count) begin
						if ($urandom_range(0, 9) < 7)
							send_short_sleep();
						else
							send_tick($urandom_range(0, 1500));
					end
					send_tick($urandom_range(500, 4000));
				end
				EP_FLOOD: begin
					// more requests than slots, then drain everything short
					repeat (QUEUE_DEPTH_TB + 2) send_short_sleep();
					send_tick({1'b1, 31'($urandom)});
				end
				EP_TIES: begin
					// same elapsed count and same quotient: equal wake times
					tie_secs = $urandom_range(0, 1);
					tie_ms   = $urandom_range(0, 50);
					count    = $urandom_range(2, 6);
					repeat (count)
						send_sleep(8'($urandom), tie_secs,
						           tie_ms * 1000 + $urandom_range(0, 999));
					send_tick($urandom_range(0, 1) ? 32'd3000 : $urandom_range(1000, 1100));
					send_tick(2000);
				end
				EP_IDLE: begin
					count = $urandom_range(1, 4);
					repeat (count) send_tick($urandom_range(0, 1));
				end
				default: begin
					// unconstrained fields; long sleeps only now and then so
					// the queue does not clog for good
					count = $urandom_range(1, 3);
					repeat (count) begin
						if ($urandom_range(0, 1))
							send_tick($urandom);
						else if ($urandom_range(0, 3) == 0)
							send_sleep(8'($urandom), $urandom, $urandom);
						else
							send_sleep(8'($urandom), $urandom_range(0, 3), $urandom);
					end
				end
			endcase
		end
		in_valid <= 1'b0;

		// let the last prediction land, then drain the results
		@(posedge clk);
		while (replies_outstanding != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatches == 0) begin
			$display("sleep_timer_queue regression: pass");
		end else begin
			$display("sleep_timer_queue regression: fail");
		end
		$finish;
	end

	// hard stop for a hung handshake or results that never come
	initial begin
		#3_000_000;
		$display("sleep_timer_queue regression: fail");
		$finish;
	end

endmodule
